[sv/bfsa_pkg.sv]
// Package for the best-fit segment allocator: types, codes and constants.
// Used by bfsa_ram, bfsa_divider and best_fit_segment_allocator.
package bfsa_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int SIZE_BITS_DEF    = 32;
    localparam logic [31:0] HEAP_SIZE_RESET = 32'd16777216;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_POOL_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] request_size;
        logic [31:0] alignment;
        logic [5:0]  handle_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  handle_out;
        logic [31:0] alloc_offset;
        logic        heap_empty;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_A_RD,
        S_A_WAIT,
        S_A_DIV,
        S_A_EVAL,
        S_A_FIND,
        S_A_BRD,
        S_A_BWAIT,
        S_A_BDIV,
        S_A_SPLIT,
        S_A_PREVRD,
        S_A_PREVWAIT,
        S_A_PREVWR,
        S_F_RD,
        S_F_WAIT,
        S_F_PRD,
        S_F_PWAIT,
        S_F_PMERGE,
        S_F_NRD,
        S_F_NWAIT,
        S_F_NMERGE,
        S_F_NNRD,
        S_F_NNWAIT,
        S_F_NNWR,
        S_DONE
    } t_state;

endpackage

[sv/bfsa_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies beyond bfsa_pkg for house consistency.
module bfsa_ram
    import bfsa_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bfsa_divider.sv]
// Restoring bit-serial remainder unit: one quotient bit per cycle.
// Depends on bfsa_pkg.
module bfsa_divider
    import bfsa_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SIZE_BITS-1:0] i_dividend,
    input  logic [SIZE_BITS-1:0] i_divisor,
    output logic                 o_done,
    output logic [SIZE_BITS-1:0] o_rem
);

    localparam int CW = $clog2(SIZE_BITS + 1);

    logic [SIZE_BITS-1:0] r_num, n_num;
    logic [SIZE_BITS:0]   r_rem, n_rem;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic [SIZE_BITS:0]   w_shift;

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_shift = {r_rem[SIZE_BITS-1:0], r_num[SIZE_BITS-1]};
        if (i_start) begin
            n_num  = i_dividend;
            n_rem  = '0;
            n_cnt  = CW'(SIZE_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = r_num << 1;
            if (w_shift >= {1'b0, i_divisor}) begin
                n_rem = w_shift - {1'b0, i_divisor};
            end else begin
                n_rem = w_shift;
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
    end

    assign o_done = !r_busy && !i_start;
    assign o_rem  = r_rem[SIZE_BITS-1:0];

endmodule

[sv/best_fit_segment_allocator.sv]
// Best-fit segment allocator top level: sequencer, segment tables, slot map.
// Depends on bfsa_pkg, bfsa_ram and bfsa_divider.
//
//  channel  | ports                                 | transfer
//  command  | start, i_cmd, busy                    | start && !busy at a rising edge
//  result   | o_done, o_result                      | one-cycle strobe, no stall
//  config   | i_cfg_valid, i_cfg_data, o_cfg_ready  | valid && ready at a rising edge
//
// Allocate walk: each segment is read and evaluated; a free one also takes a pass
// through the shared remainder unit, which sets the pace. A split adds a free-slot
// scan over up to MAX_SEGMENTS slots, a second remainder pass and the split writes.
// Allocate and free both end in the done state; the result strobe follows in the
// next cycle, with busy low. Reset and a config write run a clearing pass over every
// slot of the slot map with busy high. Config is ready only while idle and start is low.
// The result receiver cannot stall; the result shows for one cycle.
module best_fit_segment_allocator
    import bfsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int SIZE_BITS    = SIZE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_cmd,
    output logic      busy,
    output logic      o_done,
    output t_out_item o_result,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] NONE = LW'(MAX_SEGMENTS);
    localparam int SW = SIZE_BITS;
    // node word: free, prev, next, offset, length
    localparam int NW = 1 + 2 * LW + 2 * SW;

    typedef struct packed {
        logic          free;
        logic [LW-1:0] prev;
        logic [LW-1:0] next;
        logic [SW-1:0] off;
        logic [SW-1:0] len;
    } t_node;

    t_state r_state, n_state;

    logic [SW-1:0] r_heap;
    logic [MAX_SEGMENTS-1:0] r_used, n_used;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_idx, n_idx;     // sweep / walk counter
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_best, n_best;
    logic [SW-1:0] r_best_len, n_best_len;
    logic          r_have_best, n_have_best;
    logic [AW-1:0] r_node, n_node;
    logic [AW-1:0] r_fresh, n_fresh;
    logic          r_fresh_ok, n_fresh_ok;
    t_node         r_hold, n_hold;   // node being worked on
    t_node         r_aux, n_aux;     // neighbor node
    logic [SW-1:0] r_pad, n_pad;
    logic [SW-1:0] r_size, r_align;
    logic [AW-1:0] r_hin;
    logic          r_hin_ok;
    logic [1:0]    r_st, n_st;
    logic [AW-1:0] r_hout, n_hout;
    logic [SW-1:0] r_aoff, n_aoff;
    logic          r_done;
    logic          r_relink;   // prev-merge happened, follower's prev needs fixing

    logic          w_we;
    logic [AW-1:0] w_addr;
    t_node         w_wdata, w_rd;
    logic [NW-1:0] w_rbits;

    logic          w_div_start, w_div_done;
    logic [SW-1:0] w_div_rem;
    logic [SW:0]   w_need;
    logic [SW-1:0] w_rem;

    logic          w_single;
    t_node         r_headnode;

    bfsa_ram #(.WIDTH(NW), .DEPTH(MAX_SEGMENTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rbits)
    );
    assign w_rd = t_node'(w_rbits);

    // the divider latches its dividend in the cycle the node word arrives
    bfsa_divider #(.SIZE_BITS(SIZE_BITS)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(w_rd.off),
        .i_divisor (r_align),
        .o_done    (w_div_done),
        .o_rem     (w_div_rem)
    );

    assign w_div_start = (r_state == S_A_WAIT && w_rd.free) || (r_state == S_A_BWAIT);
    assign w_rem  = w_div_rem;

    always_comb begin
        if (w_rem == '0) begin
            w_need = {1'b0, r_size};
        end else begin
            w_need = {1'b0, r_size} + {1'b0, r_align} - {1'b0, w_rem};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_cmd.command == CMD_FREE) ? S_F_RD : S_A_RD;
                end
            end
            S_INIT: if (r_idx == AW'(MAX_SEGMENTS - 1)) n_state = S_IDLE;
            S_A_RD:   n_state = S_A_WAIT;
            S_A_WAIT: n_state = w_rd.free ? S_A_DIV : S_A_EVAL;
            S_A_DIV:  if (w_div_done) n_state = S_A_EVAL;
            S_A_EVAL: begin
                if (r_hold.free && {1'b0, r_hold.len} == w_need) begin
                    n_state = S_DONE;
                end else if (r_hold.next < NONE && r_idx != AW'(MAX_SEGMENTS - 1)) begin
                    n_state = S_A_RD;
                end else begin
                    n_state = S_A_FIND;
                end
            end
            S_A_FIND: begin
                if (!r_have_best) n_state = S_DONE;
                else if (r_idx == AW'(MAX_SEGMENTS - 1) || r_used[r_idx] == 1'b0)
                    n_state = S_A_BRD;
            end
            S_A_BRD:   n_state = r_fresh_ok ? S_A_BWAIT : S_DONE;
            S_A_BWAIT: n_state = S_A_BDIV;
            S_A_BDIV:  if (w_div_done) n_state = S_A_SPLIT;
            S_A_SPLIT: n_state = S_A_PREVRD;
            S_A_PREVRD: n_state = (r_hold.prev < NONE) ? S_A_PREVWAIT : S_DONE;
            S_A_PREVWAIT: n_state = S_A_PREVWR;
            S_A_PREVWR:   n_state = S_DONE;
            S_F_RD:    n_state = r_hin_ok ? S_F_WAIT : S_DONE;
            S_F_WAIT:  n_state = w_rd.free ? S_DONE : S_F_PRD;
            S_F_PRD:   n_state = (r_hold.prev < NONE) ? S_F_PWAIT : S_F_NRD;
            S_F_PWAIT: n_state = w_rd.free ? S_F_PMERGE : S_F_NRD;
            S_F_PMERGE: n_state = S_F_NRD;
            S_F_NRD:   n_state = (r_hold.next < NONE) ? S_F_NWAIT : S_F_NNWR;
            S_F_NWAIT: n_state = w_rd.free ? S_F_NMERGE : S_F_NNWR;
            S_F_NMERGE: n_state = S_F_NNRD;
            S_F_NNRD:  n_state = S_F_NNWAIT;
            S_F_NNWAIT: n_state = S_F_NNWR;
            S_F_NNWR:  n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_used = r_used; n_head = r_head; n_idx = r_idx; n_cur = r_cur;
        n_best = r_best; n_best_len = r_best_len; n_have_best = r_have_best;
        n_node = r_node; n_fresh = r_fresh; n_fresh_ok = r_fresh_ok;
        n_hold = r_hold; n_aux = r_aux; n_pad = r_pad;
        n_st = r_st; n_hout = r_hout; n_aoff = r_aoff;
        w_we = 1'b0;
        w_addr = r_cur[AW-1:0];
        w_wdata = r_hold;
        case (r_state)
            S_INIT: begin
                n_used[r_idx] = (r_idx == '0);
                n_idx = r_idx + 1'b1;
                if (r_idx == AW'(MAX_SEGMENTS - 1)) n_idx = '0;
                w_we = (r_idx == '0);
                w_addr = '0;
                w_wdata = '{free: 1'b1, prev: NONE, next: NONE, off: '0, len: r_heap};
                n_head = '0;
            end
            S_IDLE: begin
                n_cur = {1'b0, r_head};
                n_idx = '0;
                n_have_best = 1'b0;
                n_best = NONE;
                n_best_len = '1;
                n_st = ST_OK; n_hout = '0; n_aoff = '0;
            end
            S_A_RD: w_addr = r_cur[AW-1:0];
            S_A_WAIT: n_hold = w_rd;
            S_A_EVAL: begin
                if (r_hold.free && {1'b0, r_hold.len} == w_need) begin
                    n_hold.free = 1'b0;
                    w_we = 1'b1;
                    w_wdata = n_hold;
                    n_hout = r_cur[AW-1:0];
                    n_aoff = r_hold.off + (w_need[SW-1:0] - r_size);
                end else begin
                    if (r_hold.free && {1'b0, r_hold.len} > w_need
                        && (!r_have_best || r_hold.len < r_best_len)) begin
                        n_have_best = 1'b1;
                        n_best = r_cur;
                        n_best_len = r_hold.len;
                    end
                    n_cur = r_hold.next;
                    if (r_hold.next < NONE && r_idx != AW'(MAX_SEGMENTS - 1)) begin
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_idx = '0;
                        n_fresh_ok = 1'b0;
                    end
                    if (!(r_hold.next < NONE && r_idx != AW'(MAX_SEGMENTS - 1))
                        && !(n_have_best)) begin
                        n_st = ST_NO_FIT;
                    end
                end
            end
            S_A_FIND: begin
                if (!r_used[r_idx]) begin
                    n_fresh = r_idx;
                    n_fresh_ok = 1'b1;
                end else if (r_idx != AW'(MAX_SEGMENTS - 1)) begin
                    n_idx = r_idx + 1'b1;
                end
                n_cur = r_best;
            end
            S_A_BRD: begin
                w_addr = r_best[AW-1:0];
                if (!r_fresh_ok) n_st = ST_POOL_FULL;
            end
            S_A_BWAIT: n_hold = w_rd;
            S_A_SPLIT: begin
                // new front segment in fresh slot
                w_we = 1'b1;
                w_addr = r_fresh;
                w_wdata = '{free: 1'b0, prev: r_hold.prev, next: r_best,
                            off: r_hold.off, len: w_need[SW-1:0]};
                n_used[r_fresh] = 1'b1;
                n_hout = r_fresh;
                n_aoff = r_hold.off + (w_need[SW-1:0] - r_size);
                n_pad = w_need[SW-1:0];
                if (r_best[AW-1:0] == r_head) n_head = r_fresh;
            end
            S_A_PREVRD: begin
                // rewrite best tail
                w_we = 1'b1;
                w_addr = r_best[AW-1:0];
                w_wdata = '{free: 1'b1, prev: {1'b0, r_fresh}, next: r_hold.next,
                            off: r_hold.off + r_pad, len: r_hold.len - r_pad};
            end
            S_A_PREVWAIT: w_addr = r_hold.prev[AW-1:0];
            S_A_PREVWR: begin
                w_we = 1'b1;
                w_addr = r_hold.prev[AW-1:0];
                w_wdata = w_rd;
                w_wdata.next = {1'b0, r_fresh};
            end
            S_F_RD: begin
                w_addr = r_hin;
                n_node = r_hin;
                if (!r_hin_ok) n_st = ST_NOT_ALLOC;
            end
            S_F_WAIT: begin
                n_hold = w_rd;
                n_hold.free = 1'b1;
                if (w_rd.free) n_st = ST_NOT_ALLOC;
            end
            S_F_PRD: w_addr = r_hold.prev[AW-1:0];
            S_F_PWAIT: n_aux = w_rd;
            S_F_PMERGE: begin
                // absorb node into prev; prev becomes the working node
                n_used[r_node] = 1'b0;
                n_node = r_hold.prev[AW-1:0];
                n_hold = r_aux;
                n_hold.next = r_hold.next;
                n_hold.len = r_aux.len + r_hold.len;
            end
            S_F_NRD: w_addr = r_hold.next[AW-1:0];
            S_F_NWAIT: begin
                n_aux = w_rd;
                // follower stays allocated: point it back at the merged node
                if (!w_rd.free && r_relink) begin
                    w_we = 1'b1;
                    w_addr = r_hold.next[AW-1:0];
                    w_wdata = w_rd;
                    w_wdata.prev = {1'b0, r_node};
                end
            end
            S_F_NMERGE: begin
                n_used[r_hold.next[AW-1:0]] = 1'b0;
                n_hold.next = r_aux.next;
                n_hold.len = r_hold.len + r_aux.len;
            end
            S_F_NNRD: w_addr = r_hold.next[AW-1:0];
            S_F_NNWAIT: begin
                if (r_hold.next < NONE) begin
                    w_we = 1'b1;
                    w_addr = r_hold.next[AW-1:0];
                    w_wdata = w_rd;
                    w_wdata.prev = {1'b0, r_node};
                end
            end
            S_F_NNWR: begin
                w_we = 1'b1;
                w_addr = r_node;
                w_wdata = r_hold;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_heap  <= SW'(HEAP_SIZE_RESET);
            r_idx   <= '0;
            r_done  <= 1'b0;
            r_head  <= '0;
            r_relink <= 1'b0;
        end else begin
            r_done <= (r_state == S_DONE);
            if (i_cfg_valid && o_cfg_ready) begin
                r_heap  <= SW'(i_cfg_data);
                r_state <= S_INIT;
                r_idx   <= '0;
            end else begin
                r_state <= n_state;
                r_idx   <= n_idx;
            end
            r_used <= n_used;
            r_head <= n_head;
            if (r_state == S_IDLE) r_relink <= 1'b0;
            else if (r_state == S_F_PMERGE) r_relink <= 1'b1;
        end
        r_cur <= n_cur; r_best <= n_best; r_best_len <= n_best_len;
        r_have_best <= n_have_best; r_node <= n_node; r_fresh <= n_fresh;
        r_fresh_ok <= n_fresh_ok; r_aux <= n_aux; r_pad <= n_pad;
        r_st <= n_st; r_hout <= n_hout; r_aoff <= n_aoff;
        r_hold <= n_hold;
        if (r_state == S_IDLE && start) begin
            r_size  <= SW'(i_cmd.request_size);
            r_align <= (i_cmd.alignment == '0) ? SW'(1) : SW'(i_cmd.alignment);
            r_hin   <= AW'(i_cmd.handle_in);
            r_hin_ok <= (32'(i_cmd.handle_in) < 32'(MAX_SEGMENTS))
                     && r_used[AW'(i_cmd.handle_in)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && w_addr == n_head) r_headnode <= w_wdata;
    end
    assign w_single = !(r_headnode.next < NONE);

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign o_done      = r_done;
    assign o_result.status       = r_st;
    assign o_result.handle_out   = 6'(r_hout);
    assign o_result.alloc_offset = 32'(r_aoff);
    assign o_result.heap_empty   = w_single;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for best_fit_segment_allocator: table-driven directed
// commands, then random allocate/free traffic over several heap sizes.
// Depends on bfsa_pkg; the expected results come from an in-bench heap tracker.
module tb_top;
    import bfsa_pkg::*;

    localparam int NSEG = 64;
    localparam int LINK_NONE = NSEG;
    localparam longint CYCLE_LIMIT = 20000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_cmd;
    logic      busy;
    logic      o_done;
    t_out_item o_result;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    logic [31:0] i_cfg_data;

    best_fit_segment_allocator dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_cmd(i_cmd),
        .busy(busy),
        .o_done(o_done),
        .o_result(o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // heap tracker state
    logic [63:0] seg_off[NSEG];
    logic [63:0] seg_len[NSEG];
    bit          seg_free[NSEG];
    bit          seg_used[NSEG];
    int          seg_prev[NSEG];
    int          seg_next[NSEG];
    int          head_slot;

    t_out_item result_q[$];
    int        err_count;
    longint    cycles;

    function automatic void heap_reinit(logic [31:0] total);
        for (int s = 0; s < NSEG; s++) begin
            seg_off[s] = '0;
            seg_len[s] = '0;
            seg_free[s] = 0;
            seg_used[s] = 0;
            seg_prev[s] = 0;
            seg_next[s] = 0;
        end
        seg_len[0] = {32'd0, total};
        seg_free[0] = 1;
        seg_used[0] = 1;
        seg_prev[0] = LINK_NONE;
        seg_next[0] = LINK_NONE;
        head_slot = 0;
    endfunction

    function automatic logic [63:0] pad_to(logic [63:0] off, logic [63:0] align);
        logic [63:0] rem;
        rem = off % align;
        return (rem == 0) ? 64'd0 : align - rem;
    endfunction

    function automatic logic [1:0] allocate_segment(logic [63:0] size, logic [63:0] align,
                                                    output int slot, output logic [63:0] off);
        int          cur;
        int          best;
        int          fresh;
        logic [63:0] best_len;
        logic [63:0] pad;
        logic [63:0] need;
        cur = head_slot;
        best = LINK_NONE;
        fresh = LINK_NONE;
        best_len = '1;
        slot = 0;
        off = '0;
        for (int k = 0; k < NSEG && cur < NSEG; k++) begin
            if (seg_free[cur]) begin
                pad = pad_to(seg_off[cur], align);
                need = size + pad;
                if (seg_len[cur] == need) begin
                    seg_free[cur] = 0;
                    slot = cur;
                    off = seg_off[cur] + pad;
                    return ST_OK;
                end
                if (seg_len[cur] > need && seg_len[cur] < best_len) begin
                    best_len = seg_len[cur];
                    best = cur;
                end
            end
            cur = seg_next[cur];
        end
        if (best >= NSEG) return ST_NO_FIT;
        for (int s = 0; s < NSEG; s++) begin
            if (!seg_used[s]) begin
                fresh = s;
                break;
            end
        end
        if (fresh >= NSEG) return ST_POOL_FULL;
        pad = pad_to(seg_off[best], align);
        need = size + pad;
        seg_used[fresh] = 1;
        seg_off[fresh] = seg_off[best];
        seg_len[fresh] = need;
        seg_free[fresh] = 0;
        seg_prev[fresh] = seg_prev[best];
        seg_next[fresh] = best;
        if (seg_prev[best] < NSEG) seg_next[seg_prev[best]] = fresh;
        seg_prev[best] = fresh;
        seg_len[best] -= need;
        seg_off[best] += need;
        if (best == head_slot) head_slot = fresh;
        slot = fresh;
        off = seg_off[fresh] + pad;
        return ST_OK;
    endfunction

    function automatic logic [1:0] free_segment(int h);
        int node;
        int p;
        int n;
        int nn;
        node = h;
        if (!seg_used[node] || seg_free[node]) return ST_NOT_ALLOC;
        seg_free[node] = 1;
        p = seg_prev[node];
        if (p < NSEG && seg_free[p]) begin
            n = seg_next[node];
            seg_next[p] = n;
            if (n < NSEG) seg_prev[n] = p;
            seg_len[p] += seg_len[node];
            seg_used[node] = 0;
            seg_free[node] = 0;
            node = p;
        end
        n = seg_next[node];
        if (n < NSEG && seg_free[n]) begin
            nn = seg_next[n];
            if (nn < NSEG) seg_prev[nn] = node;
            seg_next[node] = nn;
            seg_len[node] += seg_len[n];
            seg_used[n] = 0;
            seg_free[n] = 0;
        end
        return ST_OK;
    endfunction

    function automatic t_out_item heap_outcome(t_in_item c);
        t_out_item   r;
        int          slot;
        logic [63:0] off;
        logic [63:0] align;
        r = '0;
        slot = 0;
        off = '0;
        align = (c.alignment == 0) ? 64'd1 : {32'd0, c.alignment};
        if (c.command == CMD_ALLOC) begin
            r.status = allocate_segment({32'd0, c.request_size}, align, slot, off);
            if (r.status == ST_OK) begin
                r.handle_out = slot[5:0];
                r.alloc_offset = off[31:0];
            end
        end else begin
            r.status = free_segment(int'(c.handle_in));
        end
        r.heap_empty = !(head_slot < NSEG && seg_next[head_slot] < NSEG);
        return r;
    endfunction

    // issue one command after an optional gap; start stays high across back-to-back items
    task automatic issue_command(t_in_item c, int gap, bit typed, t_out_item want);
        t_out_item r;
        if (gap > 0) begin
            start <= 1'b0;
            @(negedge i_clk);
            while (busy) @(negedge i_clk);
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        r = heap_outcome(c);
        result_q.push_back(typed ? want : r);
    endtask

    task automatic write_heap_size(logic [31:0] total);
        start <= 1'b0;
        @(negedge i_clk);
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= total;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        heap_reinit(total);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 12) return 0;
        if (roll < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_item make_cmd(bit cmd, logic [31:0] size, logic [31:0] align,
                                          logic [5:0] h);
        t_in_item c;
        c.command = cmd;
        c.request_size = size;
        c.alignment = align;
        c.handle_in = h;
        return c;
    endfunction

    function automatic t_out_item make_res(logic [1:0] st, logic [5:0] h, logic [31:0] off,
                                           logic empty);
        t_out_item r;
        r.status = st;
        r.handle_out = h;
        r.alloc_offset = off;
        r.heap_empty = empty;
        return r;
    endfunction

    function automatic t_in_item random_cmd(logic [31:0] total);
        t_in_item   c;
        int         live[$];
        int         roll;
        logic [31:0] span;
        c = make_cmd(CMD_ALLOC, $urandom(), $urandom(), 6'($urandom()));
        for (int s = 0; s < NSEG; s++) if (seg_used[s] && !seg_free[s]) live.push_back(s);
        roll = $urandom_range(0, 99);
        span = (total == 0) ? 32'd1 : total;
        if (roll < 50) begin
            c.request_size = ($urandom_range(0, 3) == 0) ? $urandom() :
                             $urandom() % ((span >> $urandom_range(2, 6)) + 1);
            case ($urandom_range(0, 5))
                0: c.alignment = 32'd0;
                1: c.alignment = $urandom();
                default: c.alignment = 32'd1 << $urandom_range(0, 12);
            endcase
        end else if (roll < 92 && live.size() != 0) begin
            c.command = CMD_FREE;
            c.handle_in = 6'(live[$urandom_range(0, live.size() - 1)]);
        end else begin
            c.command = 1'($urandom_range(0, 1));
        end
        return c;
    endfunction

    // compare each strobed result against the oldest pending one
    always @(negedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done) begin
            if (result_q.size() == 0) begin
                $error("unexpected result %p", o_result);
                err_count++;
            end else begin
                want = result_q.pop_front();
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    err_count++;
                end
                if (o_result.handle_out !== want.handle_out) begin
                    $error("handle_out: expected %0d, got %0d", want.handle_out,
                           o_result.handle_out);
                    err_count++;
                end
                if (o_result.alloc_offset !== want.alloc_offset) begin
                    $error("alloc_offset: expected %0h, got %0h", want.alloc_offset,
                           o_result.alloc_offset);
                    err_count++;
                end
                if (o_result.heap_empty !== want.heap_empty) begin
                    $error("heap_empty: expected %0d, got %0d", want.heap_empty,
                           o_result.heap_empty);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    typedef struct {
        t_in_item  c;
        bit        typed;
        t_out_item want;
    } t_row;

    t_row directed[$];

    initial begin
        logic [31:0] sizes[8];
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        err_count = 0;
        cycles = 0;
        heap_reinit(HEAP_SIZE_RESET);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed = '{
            '{make_cmd(CMD_FREE, 0, 1, 0), 1, make_res(ST_NOT_ALLOC, 0, 0, 1)},
            '{make_cmd(CMD_FREE, '1, '1, 6'd63), 1, make_res(ST_NOT_ALLOC, 0, 0, 1)},
            '{make_cmd(CMD_ALLOC, '1, 1, 0), 1, make_res(ST_NO_FIT, 0, 0, 1)},
            '{make_cmd(CMD_ALLOC, 16, 1, 0), 1, make_res(ST_OK, 1, 0, 0)},
            '{make_cmd(CMD_FREE, 0, 0, 1), 1, make_res(ST_OK, 0, 0, 1)},
            '{make_cmd(CMD_FREE, 0, 0, 1), 1, make_res(ST_NOT_ALLOC, 0, 0, 1)},
            '{make_cmd(CMD_ALLOC, 0, 0, 0), 0, '0},
            '{make_cmd(CMD_ALLOC, 100, 4096, 0), 0, '0},
            '{make_cmd(CMD_ALLOC, 7, '1, 0), 0, '0},
            '{make_cmd(CMD_ALLOC, 5, 3, 0), 0, '0},
            '{make_cmd(CMD_FREE, 0, 0, 2), 0, '0},
            '{make_cmd(CMD_FREE, 0, 0, 1), 0, '0},
            '{make_cmd(CMD_ALLOC, 32'hFFFF_FFF0, '1, 0), 0, '0},
            '{make_cmd(CMD_FREE, 0, 0, 3), 0, '0},
            '{make_cmd(CMD_FREE, 0, 0, 4), 0, '0},
            '{make_cmd(CMD_ALLOC, HEAP_SIZE_RESET, 1, 0), 0, '0},
            '{make_cmd(CMD_FREE, 0, 0, 0), 0, '0}
        };
        foreach (directed[i])
            issue_command(directed[i].c, pick_gap(), directed[i].typed, directed[i].want);

        // fill the slot pool, then hit pool-full and an exact fit with no slot left
        write_heap_size(32'd1000);
        for (int i = 0; i < 63; i++)
            issue_command(make_cmd(CMD_ALLOC, 1, 1, 0), pick_gap(), 0, '0);
        issue_command(make_cmd(CMD_ALLOC, 2, 1, 0), 0, 1, make_res(ST_POOL_FULL, 0, 0, 0));
        issue_command(make_cmd(CMD_ALLOC, 937, 1, 0), 0, 0, '0);

        write_heap_size(32'd0);
        issue_command(make_cmd(CMD_ALLOC, 0, 1, 0), 0, 1, make_res(ST_OK, 0, 0, 1));
        issue_command(make_cmd(CMD_ALLOC, 1, 1, 0), 0, 1, make_res(ST_NO_FIT, 0, 0, 1));

        sizes = '{32'd1, '1, HEAP_SIZE_RESET, 32'd4096, 32'd0,
                  $urandom_range(64, 65535), $urandom(), 32'd256};
        foreach (sizes[p]) begin
            write_heap_size(sizes[p]);
            for (int i = 0; i < 135; i++)
                issue_command(random_cmd(sizes[p]), pick_gap(), 0, '0);
        end

        start <= 1'b0;
        @(negedge i_clk);
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (50) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
